// ===== rtl/tds_pkg.sv =====
// ---------------------------------------------------------------------------
// Tridiagonal solver package
// Shared row item type, queue status and fixed-point helpers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tds_pkg;

    localparam int DATA_W = 32;
    localparam int IDX_W  = 6;

    localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
    localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

    // One classified row as it travels from front to back
    typedef struct packed {
        logic signed [DATA_W-1:0] diag;
        logic signed [DATA_W-1:0] upper;
        logic signed [DATA_W-1:0] lower;
        logic signed [DATA_W-1:0] rhs;
        logic                     last;
        logic [IDX_W-1:0]         idx;
    } row_t;

    // Queue status seen by the back end
    typedef struct packed {
        logic       avail;
        logic [1:0] count;
    } q_stat_t;

    // Clamp a wide signed value to 32 bits
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [65:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > SAT_MAX)
            r = 32'sh7fffffff;
        else if (v < SAT_MIN)
            r = 32'sh80000000;
        else
            r = v[DATA_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/tridiagonal_system_solver.sv =====
// ---------------------------------------------------------------------------
// Tridiagonal system solver
// Thomas algorithm in signed fixed point: rows in, solutions out in order.
// ---------------------------------------------------------------------------
// Per row: two multiplies and two serial divides (one on the final row),
// with handshakes; a zero pivot skips the divides. The final row adds a
// back-substitution pass over each unknown above it, then emits the results
// in index order, each held until out_ready takes it. The front queue
// keeps taking up to two rows while the back end works.
// Reset is asynchronous and clears control state; stores need no clearing.
`timescale 1ns / 1ps
`default_nettype none

module tridiagonal_system_solver
    import tds_pkg::*;
#(
    parameter int MAX_ROWS  = 64,
    parameter int FRAC_BITS = 16
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic signed [DATA_W-1:0] diag_value,
    input  wire logic signed [DATA_W-1:0] upper_value,
    input  wire logic signed [DATA_W-1:0] lower_value,
    input  wire logic signed [DATA_W-1:0] rhs_value,
    input  wire logic                     final_row,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic signed [DATA_W-1:0]      solution_value,
    output logic [IDX_W-1:0]              solution_index,
    output logic                          singular,
    output logic                          run_end
);

    row_t    row_q;
    q_stat_t q_stat;
    logic    pop;

    tds_front #(
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .diag_value  (diag_value),
        .upper_value (upper_value),
        .lower_value (lower_value),
        .rhs_value   (rhs_value),
        .final_row   (final_row),
        .pop         (pop),
        .row_out     (row_q),
        .stat        (q_stat)
    );

    tds_back #(
        .MAX_ROWS  (MAX_ROWS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .row_in         (row_q),
        .stat           (q_stat),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .solution_value (solution_value),
        .solution_index (solution_index),
        .singular       (singular),
        .run_end        (run_end)
    );

`ifndef SYNTHESIS
    // Singular runs give zero values
    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && singular |-> solution_value == '0)
        else $error("singular result with nonzero value");

    // Queue never holds more than two rows
    a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.count != 2'd3)
        else $error("row queue overflow");

    // Queue pops only when it holds a row
    a_pop_avail: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_stat.avail && q_stat.count != 2'd0)
        else $error("pop from empty row queue");

    // Index runs in order within a run
    a_idx_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !run_end |=> ##2 out_valid
            && solution_index == $past(solution_index, 3) + 1'b1)
        else $error("solution index out of order");
`endif

endmodule

`default_nettype wire

// ===== rtl/tds_front.sv =====
// ---------------------------------------------------------------------------
// Tridiagonal solver front end
// Accepts rows, tags each with its index and last mark, and queues them.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tds_front
    import tds_pkg::*;
#(
    parameter int MAX_ROWS = 64
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic signed [DATA_W-1:0] diag_value,
    input  wire logic signed [DATA_W-1:0] upper_value,
    input  wire logic signed [DATA_W-1:0] lower_value,
    input  wire logic signed [DATA_W-1:0] rhs_value,
    input  wire logic                     final_row,
    input  wire logic                     pop,
    output row_t                          row_out,
    output q_stat_t                       stat
);

    row_t             q_mem [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic [IDX_W-1:0] row_cnt_reg;
    logic             push;
    logic             do_pop;
    logic             is_last;
    row_t             entry;

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign do_pop   = pop && (count_reg != 2'd0);
    assign is_last  = final_row || (row_cnt_reg == IDX_W'(MAX_ROWS - 1));

    // Classify the incoming row
    always_comb
    begin
        entry.diag  = diag_value;
        entry.upper = upper_value;
        entry.lower = lower_value;
        entry.rhs   = rhs_value;
        entry.last  = is_last;
        entry.idx   = row_cnt_reg;
    end

    // Store queue entries
    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= entry;
    end

    // Advance pointers, count and row index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= 1'b0;
            rd_ptr_reg  <= 1'b0;
            count_reg   <= 2'd0;
            row_cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg  <= ~wr_ptr_reg;
                row_cnt_reg <= is_last ? '0 : row_cnt_reg + 1'b1;
            end
            if (do_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, do_pop};
        end
    end

    assign row_out    = q_mem[rd_ptr_reg];
    assign stat.avail = (count_reg != 2'd0);
    assign stat.count = count_reg;

endmodule

`default_nettype wire

// ===== rtl/tds_div.sv =====
// ---------------------------------------------------------------------------
// Tridiagonal solver divider
// Radix-2 restoring fixed-point divide, (num << FRAC_BITS) / den, saturated.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tds_div
    import tds_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic signed [DATA_W-1:0] num,
    input  wire logic signed [DATA_W-1:0] den,
    output logic                          done,
    output logic signed [DATA_W-1:0]      quo
);

    localparam int DVW = DATA_W + FRAC_BITS;

    logic                     busy_reg;
    logic                     done_reg;
    logic [5:0]               cnt_reg;
    logic [32:0]              rem_reg;
    logic [32:0]              dvd_reg;
    logic [32:0]              q_reg;
    logic [DATA_W-1:0]        den_reg;
    logic                     neg_reg;
    logic                     ovf_reg;
    logic signed [DATA_W-1:0] quo_reg;

    logic [DATA_W-1:0] num_mag;
    logic [DATA_W-1:0] den_mag;
    logic [DVW-1:0]    dividend;
    logic [32:0]       trial;
    logic              ge;
    logic [32:0]       q_next;

    always_comb
    begin
        num_mag  = num[DATA_W-1] ? DATA_W'(-num) : DATA_W'(num);
        den_mag  = den[DATA_W-1] ? DATA_W'(-den) : DATA_W'(den);
        dividend = {num_mag, {FRAC_BITS{1'b0}}};
        trial    = {rem_reg[31:0], dvd_reg[32]};
        ge       = (trial >= {1'b0, den_reg});
        q_next   = {q_reg[31:0], ge};
    end

    // Iterate one quotient bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (!busy_reg)
            begin
                if (start)
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= '0;
                    rem_reg  <= 33'(dividend[DVW-1:33]);
                    dvd_reg  <= dividend[32:0];
                    q_reg    <= '0;
                    den_reg  <= den_mag;
                    neg_reg  <= num[DATA_W-1] ^ den[DATA_W-1];
                    ovf_reg  <= (33'(dividend[DVW-1:33]) >= {1'b0, den_mag});
                end
            end
            else
            begin
                rem_reg <= ge ? trial - {1'b0, den_reg} : trial;
                dvd_reg <= {dvd_reg[31:0], 1'b0};
                q_reg   <= q_next;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 6'd32)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                    if (neg_reg)
                        quo_reg <= (ovf_reg || q_next > 33'h080000000)
                                   ? 32'sh80000000 : -$signed(q_next[31:0]);
                    else
                        quo_reg <= (ovf_reg || q_next > 33'h07fffffff)
                                   ? 32'sh7fffffff : $signed(q_next[31:0]);
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

// ===== rtl/tds_back.sv =====
// ---------------------------------------------------------------------------
// Tridiagonal solver back end
// Forward elimination per row, back substitution and in-order result output.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tds_back
    import tds_pkg::*;
#(
    parameter int MAX_ROWS  = 64,
    parameter int FRAC_BITS = 16
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  row_t                          row_in,
    input  q_stat_t                       stat,
    output logic                          pop,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic signed [DATA_W-1:0]      solution_value,
    output logic [IDX_W-1:0]              solution_index,
    output logic                          singular,
    output logic                          run_end
);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL_R, S_MUL_F, S_PIV, S_WAIT_R, S_WAIT_F, S_STORE,
        S_BS_RD, S_BS_MUL, S_BS_SUB, S_EM_RD, S_EM_LD, S_EM_HOLD
    } state_t;

    state_t                   state_reg;
    row_t                     row_reg;
    logic signed [63:0]       prod_reg;
    logic signed [DATA_W-1:0] pivot_reg;
    logic signed [DATA_W-1:0] num_reg;
    logic signed [DATA_W-1:0] ratio_reg;
    logic signed [DATA_W-1:0] fwd_reg;
    logic signed [DATA_W-1:0] prev_ratio_reg;
    logic signed [DATA_W-1:0] prev_fwd_reg;
    logic signed [DATA_W-1:0] x_reg;
    logic                     zsp_reg;
    logic [IDX_W-1:0]         bi_reg;
    logic [IDX_W-1:0]         j_reg;
    logic                     div_start_reg;
    logic signed [DATA_W-1:0] div_num_reg;
    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] sol_val_reg;
    logic [IDX_W-1:0]         sol_idx_reg;
    logic                     sing_reg;
    logic                     end_reg;

    logic signed [DATA_W-1:0] ratio_mem [MAX_ROWS];
    logic signed [DATA_W-1:0] fwd_mem   [MAX_ROWS];
    logic signed [DATA_W-1:0] sol_mem   [MAX_ROWS];
    logic signed [DATA_W-1:0] ratio_q_reg;
    logic signed [DATA_W-1:0] fwd_q_reg;
    logic signed [DATA_W-1:0] sol_q_reg;

    logic                     div_done;
    logic signed [DATA_W-1:0] div_quo;
    logic signed [DATA_W-1:0] lower_eff;
    logic signed [65:0]       prod_shift;
    logic signed [DATA_W-1:0] pivot_next;
    logic signed [DATA_W-1:0] num_next;
    logic signed [DATA_W-1:0] x_next;
    logic                     sol_we;
    logic [IDX_W-1:0]         sol_waddr;
    logic signed [DATA_W-1:0] sol_wdata;

    tds_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (div_num_reg),
        .den   (pivot_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    // Shared fixed-point arithmetic around the product register
    always_comb
    begin
        lower_eff  = (row_reg.idx == '0) ? '0 : row_reg.lower;
        prod_shift = 66'(prod_reg >>> FRAC_BITS);
        pivot_next = sat32(66'(row_reg.diag) - prod_shift);
        num_next   = sat32(66'(row_reg.rhs) - prod_shift);
        x_next     = sat32(66'(fwd_q_reg) - prod_shift);
    end

    assign pop       = (state_reg == S_IDLE) && stat.avail;
    assign sol_we    = ((state_reg == S_STORE) && row_reg.last) || (state_reg == S_BS_SUB);
    assign sol_waddr = (state_reg == S_STORE) ? row_reg.idx : bi_reg;
    assign sol_wdata = (state_reg == S_STORE) ? fwd_reg : x_next;

    // Ratio and forward stores
    always_ff @(posedge clk)
    begin
        if (state_reg == S_STORE)
        begin
            ratio_mem[row_reg.idx] <= ratio_reg;
            fwd_mem[row_reg.idx]   <= fwd_reg;
        end
        ratio_q_reg <= ratio_mem[bi_reg];
        fwd_q_reg   <= fwd_mem[bi_reg];
    end

    // Solution buffer for index-order output
    always_ff @(posedge clk)
    begin
        if (sol_we)
            sol_mem[sol_waddr] <= sol_wdata;
        sol_q_reg <= sol_mem[j_reg];
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            prev_ratio_reg <= '0;
            prev_fwd_reg   <= '0;
            zsp_reg        <= 1'b0;
            div_start_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            bi_reg         <= '0;
            j_reg          <= '0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (stat.avail)
                    begin
                        row_reg   <= row_in;
                        state_reg <= S_MUL_R;
                    end
                end
                S_MUL_R:
                begin
                    prod_reg  <= 64'(lower_eff) * 64'(prev_ratio_reg);
                    state_reg <= S_MUL_F;
                end
                S_MUL_F:
                begin
                    pivot_reg <= pivot_next;
                    prod_reg  <= 64'(lower_eff) * 64'(prev_fwd_reg);
                    state_reg <= S_PIV;
                end
                S_PIV:
                begin
                    num_reg <= num_next;
                    if (pivot_reg == '0)
                    begin
                        zsp_reg   <= 1'b1;
                        ratio_reg <= '0;
                        fwd_reg   <= '0;
                        state_reg <= S_STORE;
                    end
                    else if (row_reg.last)
                    begin
                        ratio_reg     <= '0;
                        div_start_reg <= 1'b1;
                        div_num_reg   <= num_next;
                        state_reg     <= S_WAIT_F;
                    end
                    else
                    begin
                        div_start_reg <= 1'b1;
                        div_num_reg   <= row_reg.upper;
                        state_reg     <= S_WAIT_R;
                    end
                end
                S_WAIT_R:
                begin
                    if (div_done)
                    begin
                        ratio_reg     <= div_quo;
                        div_start_reg <= 1'b1;
                        div_num_reg   <= num_reg;
                        state_reg     <= S_WAIT_F;
                    end
                end
                S_WAIT_F:
                begin
                    if (div_done)
                    begin
                        fwd_reg   <= div_quo;
                        state_reg <= S_STORE;
                    end
                end
                S_STORE:
                begin
                    prev_ratio_reg <= ratio_reg;
                    prev_fwd_reg   <= fwd_reg;
                    x_reg          <= fwd_reg;
                    j_reg          <= '0;
                    if (!row_reg.last)
                        state_reg <= S_IDLE;
                    else if (row_reg.idx == '0)
                        state_reg <= S_EM_RD;
                    else
                    begin
                        bi_reg    <= row_reg.idx - 1'b1;
                        state_reg <= S_BS_RD;
                    end
                end
                S_BS_RD:
                begin
                    state_reg <= S_BS_MUL;
                end
                S_BS_MUL:
                begin
                    prod_reg  <= 64'(ratio_q_reg) * 64'(x_reg);
                    state_reg <= S_BS_SUB;
                end
                S_BS_SUB:
                begin
                    x_reg <= x_next;
                    if (bi_reg == '0)
                        state_reg <= S_EM_RD;
                    else
                    begin
                        bi_reg    <= bi_reg - 1'b1;
                        state_reg <= S_BS_RD;
                    end
                end
                S_EM_RD:
                begin
                    state_reg <= S_EM_LD;
                end
                S_EM_LD:
                begin
                    out_valid_reg <= 1'b1;
                    sol_val_reg   <= zsp_reg ? '0 : sol_q_reg;
                    sol_idx_reg   <= j_reg;
                    sing_reg      <= zsp_reg;
                    end_reg       <= (j_reg == row_reg.idx);
                    state_reg     <= S_EM_HOLD;
                end
                S_EM_HOLD:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (end_reg)
                        begin
                            prev_ratio_reg <= '0;
                            prev_fwd_reg   <= '0;
                            zsp_reg        <= 1'b0;
                            state_reg      <= S_IDLE;
                        end
                        else
                        begin
                            j_reg     <= j_reg + 1'b1;
                            state_reg <= S_EM_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign solution_value = sol_val_reg;
    assign solution_index = sol_idx_reg;
    assign singular       = sing_reg;
    assign run_end        = end_reg;

endmodule

`default_nettype wire
